### rtl/sha_pkg.sv
// shared types, constants and functions for the sha-256 block
package sha_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;

	// one classified request from the front end
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
	} sha_req_t;

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sha_state_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

### rtl/sha_front.sv
// input stage and two-entry request queue
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  logic              message_end,
	input  logic              empty_message,
	input  logic              in_valid,
	output logic              in_ready,
	output sha_pkg::sha_req_t req,
	output logic              req_valid,
	input  logic              req_pop
);
	import sha_pkg::*;

	sha_req_t  fifo_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	logic      push;

	assign in_ready  = (cnt_q != 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rd_q];
	// empty items without end do nothing, so they are dropped here
	assign push = in_valid && in_ready && (!empty_message || message_end);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{data: data_byte, has_byte: !empty_message, last: message_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (req_pop && req_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, req_pop && req_valid};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !(req_pop && req_valid)) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !(req_pop && req_valid))
		else $error("pop from empty queue");

endmodule

### rtl/sha_core.sv
// block buffer, padding, compression rounds and digest output
module sha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_req_t req,
	input  logic              req_valid,
	output logic              req_pop,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              digest_last,
	output logic              out_valid,
	input  logic              out_ready
);
	import sha_pkg::*;

	sha_state_t  state_q, state_d;
	logic [31:0] blk_q [16];
	logic [31:0] hash_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [5:0]  pad_q;
	logic        fin_q;
	logic        tail_q;
	logic        mark_q;
	logic [2:0]  idx_q;

	logic [31:0] s0, s1, ch, maj, t1, t2, ws0, ws1, wn, wcur;
	logic [7:0]  pbyte;
	logic [5:0]  fill_n;

	assign wcur = w_q[0];
	assign s1  = rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25);
	assign ch  = (e_q & f_q) ^ (~e_q & g_q);
	assign t1  = h_q + s1 + ch + ROUND_K[rnd_q] + wcur;
	assign s0  = rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22);
	assign maj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
	assign t2  = s0 + maj;
	assign ws0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign ws1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn  = w_q[0] + ws0 + w_q[9] + ws1;
	assign fill_n = fill_q + 6'd1;

	// padding byte for slot pad_q
	always_comb begin
		if (pad_q >= LENGTH_POS && !tail_q) begin
			pbyte = len_q[8'(6'd63 - pad_q) * 8 +: 8];
		end else if (mark_q && pad_q == fill_q) begin
			pbyte = PAD_MARK;
		end else begin
			pbyte = 8'h00;
		end
	end

	always_comb begin
		state_d = state_q;
		req_pop = 1'b0;
		case (state_q)
			ST_ACCEPT: begin
				if (req_valid) begin
					req_pop = 1'b1;
					if (req.has_byte && fill_q == 6'd63) state_d = ST_LOAD;
					else if (req.last) state_d = ST_PAD;
				end
			end
			ST_PAD:   if (pad_q == 6'd63) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (tail_q || mark_q) state_d = ST_PAD;
				else if (fin_q) state_d = ST_EMIT;
				else state_d = ST_ACCEPT;
			end
			ST_EMIT:  if (out_ready && idx_q == 3'd7) state_d = ST_ACCEPT;
			default:  state_d = ST_ACCEPT;
		endcase
	end

	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = hash_q[idx_q];
	assign word_index  = idx_q;
	assign digest_last = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			fill_q  <= 6'd0;
			len_q   <= 64'd0;
			rnd_q   <= 6'd0;
			pad_q   <= 6'd0;
			fin_q   <= 1'b0;
			tail_q  <= 1'b0;
			mark_q  <= 1'b0;
			idx_q   <= 3'd0;
			for (int i = 0; i < 8; i++) hash_q[i] <= INIT_HASH[i];
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_ACCEPT: begin
					if (req_valid) begin
						if (req.has_byte) begin
							fill_q <= fill_n;
							len_q  <= len_q + 64'd8;
						end
						fin_q  <= req.last;
						mark_q <= req.last;
						// pad starts at the slot after the taken byte
						pad_q  <= req.has_byte ? fill_n : fill_q;
						tail_q <= req.has_byte ? (fill_n >= LENGTH_POS && fill_n != 6'd0)
							: (fill_q >= LENGTH_POS);
					end
				end
				ST_PAD: begin
					pad_q <= pad_q + 6'd1;
					if (pad_q == 6'd63) mark_q <= 1'b0;
				end
				ST_ROUND: rnd_q <= rnd_q + 6'd1;
				ST_FOLD: begin
					hash_q[0] <= hash_q[0] + a_q; hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q; hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q; hash_q[5] <= hash_q[5] + f_q;
					hash_q[6] <= hash_q[6] + g_q; hash_q[7] <= hash_q[7] + h_q;
					if (tail_q) begin
						// second final block: zeros then length
						tail_q <= 1'b0;
						fin_q  <= 1'b1;
						fill_q <= 6'd0;
						pad_q  <= 6'd0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) hash_q[i] <= INIT_HASH[i];
							fill_q <= 6'd0;
							len_q  <= 64'd0;
							fin_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// mark_q drops at the end of the first pad pass so the mark is written once
	always_ff @(posedge clk) begin
		if (state_q == ST_ACCEPT && req_valid && req.has_byte) begin
			blk_q[fill_q[5:2]][8'(3 - fill_q[1:0]) * 8 +: 8] <= req.data;
		end
		if (state_q == ST_PAD) begin
			blk_q[pad_q[5:2]][8'(3 - pad_q[1:0]) * 8 +: 8] <= pbyte;
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
			a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
			e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_ready) |=> (state_q == ST_EMIT && $stable(idx_q)))
		else $error("stalled digest word moved");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACCEPT) |-> !req_pop)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> state_q == ST_FOLD)
		else $error("round count slip");

endmodule

### rtl/sha256_message_digest_top.sv
// top level of the byte-fed sha-256 digest block
// usage:
//   input channel: data_byte, message_end, empty_message with in_valid/in_ready;
//   one request is one message byte, or an empty marker that ends a message
//   output channel: digest_word, word_index, digest_last with out_valid/out_ready;
//   eight words follow each request marked message_end, word 0 first
// timing:
//   bytes are taken one per cycle while the core is accepting; the byte that
//   fills a 64-byte block starts a compression (load, 64 rounds, fold) on the
//   single shared round unit; the end of a message adds a padding sweep of one
//   slot per cycle from the fill point to the end of the block, plus a
//   compression per final block (one or two); a second final block, or one that
//   starts empty, sweeps all 64 slots; then the eight digest words are sent
//   a two-entry queue holds up to two requests arriving while the core compresses
// reset:
//   arst_n clears the queue and loads the initial hash values
// stalls:
//   if out_ready is low the current digest word holds; the queue fills and
//   then in_ready drops
module sha256_message_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        message_end,
	input  logic        empty_message,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last,
	output logic        out_valid,
	input  logic        out_ready
);
	import sha_pkg::*;

	sha_req_t req;
	logic     req_valid, req_pop;

	// front end: classify and queue requests
	sha_front u_front (
		.clk, .arst_n, .data_byte, .message_end, .empty_message,
		.in_valid, .in_ready, .req, .req_valid, .req_pop
	);

	// back end: block assembly, compression and digest output
	sha_core u_core (
		.clk, .arst_n, .req, .req_valid, .req_pop,
		.digest_word, .word_index, .digest_last, .out_valid, .out_ready
	);

endmodule
